[src/ntlv_pkg.sv]
// Shared types and constants for the nested tag-length-value stream parser.
// Used by ntlv_step, ntlv_outq and nested_tlv_stream_parser; no dependencies.
`timescale 1ns / 1ps

package ntlv_pkg;

  localparam int MAX_DEPTH   = 16;
  localparam int COUNT_WIDTH = 24;
  localparam int LEVEL_W     = $clog2(MAX_DEPTH + 1);

  // Marker bytes of the format.
  localparam logic [7:0] MK_NUL     = 8'h00;
  localparam logic [7:0] MK_END     = 8'h01;
  localparam logic [7:0] MK_COPEN   = 8'h02;
  localparam logic [7:0] MK_CCLOSE  = 8'h03;
  localparam logic [7:0] MK_FOPEN   = 8'h04;
  localparam logic [7:0] MK_FCLOSE  = 8'h05;

  // Byte classes.
  localparam logic [3:0] CL_STREAM_END  = 4'd0;
  localparam logic [3:0] CL_COPEN       = 4'd1;
  localparam logic [3:0] CL_CNAME       = 4'd2;
  localparam logic [3:0] CL_NAME_NUL    = 4'd3;
  localparam logic [3:0] CL_FOPEN       = 4'd4;
  localparam logic [3:0] CL_FNAME       = 4'd5;
  localparam logic [3:0] CL_LEN_LO      = 4'd6;
  localparam logic [3:0] CL_LEN_HI      = 4'd7;
  localparam logic [3:0] CL_DATA        = 4'd8;
  localparam logic [3:0] CL_FIELD_NUL   = 4'd9;
  localparam logic [3:0] CL_FCLOSE      = 4'd10;
  localparam logic [3:0] CL_CCLOSE      = 4'd11;
  localparam logic [3:0] CL_IGNORED     = 4'd12;

  // Parse status codes.
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [8:0] {
    PH_TOP    = 9'b000000001,
    PH_CNAME  = 9'b000000010,
    PH_BODY   = 9'b000000100,
    PH_FNAME  = 9'b000001000,
    PH_LENLO  = 9'b000010000,
    PH_LENHI  = 9'b000100000,
    PH_DATA   = 9'b001000000,
    PH_FNUL   = 9'b010000000,
    PH_FCLOSE = 9'b100000000
  } phase_t;

  typedef struct packed {
    phase_t                   phase;
    logic [LEVEL_W-1:0]       level;
    logic [15:0]              left;
    logic [COUNT_WIDTH-1:0]   pos;
    logic                     finished;
    logic                     failed;
  } parse_state_t;

  typedef struct packed {
    logic [3:0]  byte_class;
    logic [7:0]  byte_out;
    logic [4:0]  nesting_depth;
    logic [1:0]  parse_status;
    logic [23:0] consumed_count;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } outq_stat_t;

endpackage

[src/ntlv_step.sv]
// Next-state and result logic for one byte of the parser.
// Purely combinational; depends on ntlv_pkg.
`timescale 1ns / 1ps

module ntlv_step (
  input  ntlv_pkg::parse_state_t cur,
  input  logic [7:0]             byte_value,
  input  logic                   last_byte,
  input  logic                   single_message_mode,
  output ntlv_pkg::parse_state_t nxt,
  output ntlv_pkg::result_t      res
);
  import ntlv_pkg::*;

  parse_state_t           upd;
  logic [3:0]             cls;
  logic                   bad;
  logic                   done;
  logic [15:0]            left_dec;
  logic [15:0]            len_full;
  logic [1:0]             status;

  assign left_dec = (cur.left != 16'd0) ? cur.left - 16'd1 : 16'd0;
  assign len_full = {byte_value, cur.left[7:0]};

  always_comb begin
    upd  = cur;
    cls  = CL_IGNORED;
    bad  = 1'b0;
    done = 1'b0;
    if (!cur.finished && !cur.failed) begin
      if (cur.pos != {COUNT_WIDTH{1'b1}}) begin
        upd.pos = cur.pos + COUNT_WIDTH'(1);
      end
      case (cur.phase)
        PH_TOP: begin
          if (byte_value == MK_COPEN) begin
            cls       = CL_COPEN;
            upd.level = LEVEL_W'(1);
            upd.phase = PH_CNAME;
          end else if (byte_value == MK_END && !single_message_mode) begin
            cls  = CL_STREAM_END;
            done = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        PH_CNAME: begin
          if (byte_value == MK_NUL) begin
            cls       = CL_NAME_NUL;
            upd.phase = PH_BODY;
          end else begin
            cls = CL_CNAME;
          end
        end
        PH_BODY: begin
          if (byte_value == MK_CCLOSE) begin
            cls       = CL_CCLOSE;
            upd.level = cur.level - LEVEL_W'(1);
            if (cur.level == LEVEL_W'(1)) begin
              upd.phase = PH_TOP;
              done      = single_message_mode;
            end
          end else if (byte_value == MK_COPEN) begin
            if (cur.level >= LEVEL_W'(MAX_DEPTH)) begin
              bad = 1'b1;
            end else begin
              cls       = CL_COPEN;
              upd.level = cur.level + LEVEL_W'(1);
              upd.phase = PH_CNAME;
            end
          end else if (byte_value == MK_FOPEN) begin
            cls       = CL_FOPEN;
            upd.phase = PH_FNAME;
          end else begin
            bad = 1'b1;
          end
        end
        PH_FNAME: begin
          if (byte_value == MK_NUL) begin
            cls       = CL_NAME_NUL;
            upd.phase = PH_LENLO;
          end else begin
            cls = CL_FNAME;
          end
        end
        PH_LENLO: begin
          cls       = CL_LEN_LO;
          upd.left  = {8'd0, byte_value};
          upd.phase = PH_LENHI;
        end
        PH_LENHI: begin
          cls       = CL_LEN_HI;
          upd.left  = len_full;
          upd.phase = (len_full != 16'd0) ? PH_DATA : PH_FNUL;
        end
        PH_DATA: begin
          cls      = CL_DATA;
          upd.left = left_dec;
          if (left_dec == 16'd0) begin
            upd.phase = PH_FNUL;
          end
        end
        PH_FNUL: begin
          if (byte_value == MK_NUL) begin
            cls       = CL_FIELD_NUL;
            upd.phase = PH_FCLOSE;
          end else begin
            bad = 1'b1;
          end
        end
        PH_FCLOSE: begin
          if (byte_value == MK_FCLOSE) begin
            cls       = CL_FCLOSE;
            upd.phase = PH_BODY;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      if (bad) begin
        cls        = CL_IGNORED;
        upd.failed = 1'b1;
      end else if (done) begin
        upd.finished = 1'b1;
      end else if (last_byte) begin
        // A clean buffer end is only legal between containers in stream mode.
        if (upd.phase == PH_TOP && !single_message_mode) begin
          upd.finished = 1'b1;
        end else begin
          upd.failed = 1'b1;
        end
      end
      if (upd.finished || upd.failed) begin
        upd.level = '0;
      end
    end
  end

  always_comb begin
    if (upd.failed) begin
      status = ST_BAD;
    end else if (upd.finished) begin
      status = ST_DONE;
    end else begin
      status = ST_BUSY;
    end
  end

  assign res.byte_class     = cls;
  assign res.byte_out       = byte_value;
  assign res.nesting_depth  = 5'(upd.level);
  assign res.parse_status   = status;
  assign res.consumed_count = (status == ST_DONE) ? 24'(upd.pos) : 24'd0;

  // The parse context returns to reset after the final byte of a buffer.
  always_comb begin
    nxt = upd;
    if (last_byte) begin
      nxt.phase    = PH_TOP;
      nxt.level    = '0;
      nxt.left     = 16'd0;
      nxt.pos      = '0;
      nxt.finished = 1'b0;
      nxt.failed   = 1'b0;
    end
  end

endmodule

[src/ntlv_outq.sv]
// Two-entry result queue: an output register plus a skid slot.
// Depends on ntlv_pkg for the result type.
`timescale 1ns / 1ps

module ntlv_outq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ntlv_pkg::result_t      push_data,
  input  logic                   pop,
  output ntlv_pkg::result_t      head,
  output ntlv_pkg::outq_stat_t   stat
);
  import ntlv_pkg::*;

  result_t    slot0;
  result_t    slot1;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case (fill)
        2'd0: begin
          if (push) begin
            slot0 <= push_data;
            fill  <= 2'd1;
          end
        end
        2'd1: begin
          if (push && pop) begin
            slot0 <= push_data;
          end else if (push) begin
            slot1 <= push_data;
            fill  <= 2'd2;
          end else if (pop) begin
            fill <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            slot0 <= slot1;
            fill  <= 2'd1;
          end
        end
        default: begin
          fill <= 2'd0;
        end
      endcase
    end
  end

  assign head       = slot0;
  assign stat.full  = (fill == 2'd2);
  assign stat.empty = (fill == 2'd0);

endmodule

[src/nested_tlv_stream_parser.sv]
// Nested tag-length-value stream parser, one byte per beat.
// The result for a byte is registered into the result queue when the byte is accepted.
// Throughput: one byte per cycle while item_stall is low; the parse state
// register closes the loop, and a two-entry result queue absorbs output stall.
// Reset (rst, synchronous, active high) clears the parse state, the queue and
// sets the registered mode to 0 (stream mode).
`timescale 1ns / 1ps

module nested_tlv_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        single_message_mode,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  byte_class,
  output logic [7:0]  byte_out,
  output logic [4:0]  nesting_depth,
  output logic [1:0]  parse_status,
  output logic [23:0] consumed_count
);
  import ntlv_pkg::*;

  logic         mode;
  parse_state_t state;
  parse_state_t state_next;
  result_t      step_res;
  result_t      head;
  outq_stat_t   qstat;
  logic         accept;
  logic         pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid) begin
      mode <= single_message_mode;
    end
  end

  assign item_stall = qstat.full;
  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;

  ntlv_step u_step (
    .cur                 (state),
    .byte_value          (byte_value),
    .last_byte           (last_byte),
    .single_message_mode (mode),
    .nxt                 (state_next),
    .res                 (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase    <= PH_TOP;
      state.level    <= '0;
      state.left     <= 16'd0;
      state.pos      <= '0;
      state.finished <= 1'b0;
      state.failed   <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  ntlv_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  assign result_valid   = !qstat.empty;
  assign byte_class     = head.byte_class;
  assign byte_out       = head.byte_out;
  assign nesting_depth  = head.nesting_depth;
  assign parse_status   = head.parse_status;
  assign consumed_count = head.consumed_count;

  // A finished or failed parse always reports depth zero.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && parse_status != ST_BUSY) |-> (nesting_depth == 5'd0))
    else $error("nonzero depth after parse end");

  // The consumed count is only given with a completed status.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && parse_status != ST_DONE) |-> (consumed_count == 24'd0))
    else $error("consumed count outside completion");

  // A result leaves the queue only when it was taken.
  assert property (@(posedge clk) disable iff (rst)
    ($fell(result_valid) && $past(!rst)) |-> $past(!result_stall))
    else $error("result dropped while stalled");

  // The queue is full only after a beat was pushed without one taken.
  assert property (@(posedge clk) disable iff (rst)
    ($rose(item_stall) && $past(!rst)) |-> $past(accept && !pop))
    else $error("queue filled without a push");

endmodule
